FILE: src/thr_pkg.sv
// Shared constants, types and state codes for the triangle height map rasterizer.
// No dependencies; every other file uses these by scoped names.
package thr_pkg;

  localparam int MAP_SIZE  = 256;
  localparam int FRAC_BITS = 8;
  localparam int ACC_BITS  = 16;

  localparam int XW     = 18;
  localparam int ZW     = 24;
  localparam int RDW    = 8;
  localparam int CW     = 17;
  localparam int IDX_W  = $clog2(MAP_SIZE);
  localparam int SA_W   = 2 * IDX_W;
  localparam int CNT_W  = SA_W;
  localparam int YI_W   = XW - FRAC_BITS;
  localparam int RC_W   = ((YI_W > IDX_W) ? YI_W : IDX_W) + 2;
  localparam int TW     = RC_W + FRAC_BITS + 1;
  localparam int XACC_W = XW + ACC_BITS + 2;
  localparam int ZACC_W = ZW + ACC_BITS + 2;
  localparam int QW     = ZACC_W + FRAC_BITS;

  localparam logic signed [ZW-1:0] EMPTY_HEIGHT = {1'b1, {(ZW-1){1'b0}}};
  localparam logic signed [ZW-1:0] TOP_HEIGHT   = {1'b0, {(ZW-1){1'b1}}};
  localparam logic signed [XW-1:0] X_TOP        = {1'b0, {(XW-1){1'b1}}};
  localparam logic signed [XW-1:0] X_BOTTOM     = {1'b1, {(XW-1){1'b0}}};
  localparam logic [CW-1:0]        CELLS_MAX    = {CW{1'b1}};

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EDGE, S_DIVX, S_MULX, S_DIVZ, S_MULZ, S_WALK_RD, S_WALK_WR,
    S_SPAN, S_ROW_RD, S_ROW_CHK, S_DIVR, S_MULR, S_PIX, S_READ_RD, S_READ_DAT, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [XW-1:0] lx;
    logic signed [ZW-1:0] lz;
    logic signed [XW-1:0] hx;
    logic signed [ZW-1:0] hz;
  } row_ent_t;

endpackage

FILE: src/thr_if.sv
// Valid/ready channel interfaces for the rasterizer: input item and result beat.
// Depends on thr_pkg for field widths.
interface thr_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [thr_pkg::XW-1:0] vertex_a_x;
  logic signed [thr_pkg::XW-1:0] vertex_a_y;
  logic signed [thr_pkg::ZW-1:0] vertex_a_z;
  logic signed [thr_pkg::XW-1:0] vertex_b_x;
  logic signed [thr_pkg::XW-1:0] vertex_b_y;
  logic signed [thr_pkg::ZW-1:0] vertex_b_z;
  logic signed [thr_pkg::XW-1:0] vertex_c_x;
  logic signed [thr_pkg::XW-1:0] vertex_c_y;
  logic signed [thr_pkg::ZW-1:0] vertex_c_z;
  logic [thr_pkg::RDW-1:0]       read_col;
  logic [thr_pkg::RDW-1:0]       read_row;

  modport source (output valid, action, vertex_a_x, vertex_a_y, vertex_a_z,
                  vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y,
                  vertex_c_z, read_col, read_row, input ready);
  modport sink (input valid, action, vertex_a_x, vertex_a_y, vertex_a_z,
                vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y,
                vertex_c_z, read_col, read_row, output ready);
endinterface

interface thr_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [thr_pkg::ZW-1:0] height_value;
  logic signed [thr_pkg::ZW-1:0] lowest_height;
  logic [thr_pkg::CW-1:0]        cells_written;

  modport source (output valid, height_value, lowest_height, cells_written, input ready);
  modport sink (input valid, height_value, lowest_height, cells_written, output ready);
endinterface

FILE: src/triangle_heightmap_rasterizer_unit.sv
// Flow: a read passes S_READ_RD and S_READ_DAT; a clear sweeps the whole store; a draw
// skips an empty edge, else finds its x and z slopes and walks its rows, then checks the
// span rows, finds the z slope of each filled one and fills it; then the result beat.
// Throughput: one item at a time; the 50-step shared divider and 18-step shift-add
// multiplier set the setup cost, the single height store write port sets one cell a cycle.
// Reset: synchronous; the height store is swept to empty after reset, during which no item
// is accepted. Depends on thr_pkg and thr_if.
module triangle_heightmap_rasterizer_unit (
  input logic      clk,
  input logic      rst_n,
  thr_in_if.sink   in_ch,
  thr_out_if.source out_ch
);

  thr_pkg::state_t state_r, state_nxt;
  logic [thr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic clr_reply_r, clr_reply_nxt;

  logic signed [thr_pkg::XW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [thr_pkg::XW-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt, cx_nxt, cy_nxt;
  logic signed [thr_pkg::ZW-1:0] az_r, bz_r, cz_r, az_nxt, bz_nxt, cz_nxt;

  logic [1:0] edge_r, edge_nxt;
  logic [thr_pkg::IDX_W-1:0] row_r, row_nxt, last_r, last_nxt, col_r, col_nxt;
  logic [thr_pkg::IDX_W:0] end_r, end_nxt;

  logic [thr_pkg::XW-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt, t_r, t_nxt, mm_r, mm_nxt;
  logic [thr_pkg::QW-1:0] quo_r, quo_nxt, pacc_r, pacc_nxt;
  logic sgn_r, sgn_nxt;
  logic [thr_pkg::XACC_W-1:0] xs_r, xs_nxt, xa_r, xa_nxt;
  logic [thr_pkg::ZACC_W-1:0] zs_r, zs_nxt, za_r, za_nxt;

  logic [thr_pkg::CW-1:0] cells_r, cells_nxt;
  logic signed [thr_pkg::ZW-1:0] min_r, min_nxt, hv_r, hv_nxt;
  logic [thr_pkg::RDW-1:0] rcol_r, rcol_nxt, rrow_r, rrow_nxt;
  logic [thr_pkg::MAP_SIZE-1:0] valid_r, valid_nxt;

  logic signed [thr_pkg::ZW-1:0] store_mem [2**thr_pkg::SA_W];
  logic signed [thr_pkg::ZW-1:0] store_rd_r, store_wd;
  logic [thr_pkg::SA_W-1:0] store_wa, store_ra;
  logic store_we;

  thr_pkg::row_ent_t row_mem [thr_pkg::MAP_SIZE];
  thr_pkg::row_ent_t row_rd_r, row_wd;
  logic row_we;

  // edge endpoints
  logic signed [thr_pkg::XW-1:0] px, py, qx, qy, e_ax, e_ay, e_bx, e_by;
  logic signed [thr_pkg::ZW-1:0] pz, qz, e_az, e_bz;
  logic signed [thr_pkg::XW:0] e_dy, e_dx;
  logic signed [thr_pkg::ZW:0] e_dz;
  logic [thr_pkg::XW:0] e_dxm;
  logic [thr_pkg::ZW:0] e_dzm;
  logic signed [thr_pkg::RC_W-1:0] e_fst, e_lst, e_fstc, e_lstc;
  logic signed [thr_pkg::TW-1:0] e_t;
  logic e_skip;

  // shared divide / multiply unit
  logic [thr_pkg::XW:0] dv_tmp;
  logic dv_ge;
  logic [thr_pkg::XW-1:0] dv_rem;
  logic [thr_pkg::QW-1:0] dv_quo, sq, ml_acc;
  logic [thr_pkg::ZACC_W-1:0] eo, eo_s, fo_s;

  // walk and fill
  logic signed [thr_pkg::XW-1:0] xv, cur_lx, cur_hx;
  logic signed [thr_pkg::ZW-1:0] zv, pz_v;
  logic signed [thr_pkg::RC_W-1:0] f_fst, f_end, f_endc;
  logic signed [thr_pkg::XW:0] f_dx;
  logic signed [thr_pkg::ZW:0] f_dz;
  logic [thr_pkg::ZW:0] f_dzm;
  logic f_skip;
  logic signed [thr_pkg::XW-1:0] ylo, yhi;
  logic signed [thr_pkg::RC_W-1:0] s_lo, s_hi;
  logic rd_inmap;
  logic signed [thr_pkg::ZW-1:0] in_az, in_bz, in_cz;

  assign in_ch.ready          = (state_r == thr_pkg::S_IDLE);
  assign out_ch.valid         = (state_r == thr_pkg::S_OUT);
  assign out_ch.height_value  = hv_r;
  assign out_ch.lowest_height = min_r;
  assign out_ch.cells_written = cells_r;

  assign in_az = (in_ch.vertex_a_z == thr_pkg::EMPTY_HEIGHT) ? -thr_pkg::TOP_HEIGHT
                                                              : in_ch.vertex_a_z;
  assign in_bz = (in_ch.vertex_b_z == thr_pkg::EMPTY_HEIGHT) ? -thr_pkg::TOP_HEIGHT
                                                              : in_ch.vertex_b_z;
  assign in_cz = (in_ch.vertex_c_z == thr_pkg::EMPTY_HEIGHT) ? -thr_pkg::TOP_HEIGHT
                                                              : in_ch.vertex_c_z;

  assign store_ra = {thr_pkg::IDX_W'(rrow_r), thr_pkg::IDX_W'(rcol_r)};
  assign rd_inmap = (32'(rcol_r) < thr_pkg::MAP_SIZE) && (32'(rrow_r) < thr_pkg::MAP_SIZE);

  always_comb begin
    unique case (edge_r)
      2'd0: begin
        px = ax_r; py = ay_r; pz = az_r; qx = bx_r; qy = by_r; qz = bz_r;
      end
      2'd1: begin
        px = bx_r; py = by_r; pz = bz_r; qx = cx_r; qy = cy_r; qz = cz_r;
      end
      default: begin
        px = cx_r; py = cy_r; pz = cz_r; qx = ax_r; qy = ay_r; qz = az_r;
      end
    endcase
    if (py > qy) begin
      e_ax = qx; e_ay = qy; e_az = qz; e_bx = px; e_by = py; e_bz = pz;
    end else begin
      e_ax = px; e_ay = py; e_az = pz; e_bx = qx; e_by = qy; e_bz = qz;
    end
    e_dy  = (thr_pkg::XW+1)'(e_by) - (thr_pkg::XW+1)'(e_ay);
    e_dx  = (thr_pkg::XW+1)'(e_bx) - (thr_pkg::XW+1)'(e_ax);
    e_dz  = (thr_pkg::ZW+1)'(e_bz) - (thr_pkg::ZW+1)'(e_az);
    e_dxm = e_dx[thr_pkg::XW] ? (thr_pkg::XW+1)'(-e_dx) : e_dx;
    e_dzm = e_dz[thr_pkg::ZW] ? (thr_pkg::ZW+1)'(-e_dz) : e_dz;
    e_fst = thr_pkg::RC_W'(e_ay >>> thr_pkg::FRAC_BITS) + thr_pkg::RC_W'(1);
    e_lst = thr_pkg::RC_W'(e_by >>> thr_pkg::FRAC_BITS);
    e_fstc = (e_fst < 0) ? '0 : e_fst;
    e_lstc = (e_lst > thr_pkg::MAP_SIZE - 1) ? thr_pkg::RC_W'(thr_pkg::MAP_SIZE - 1) : e_lst;
    e_skip = (e_dy == 0) || (e_fstc > e_lstc);
    e_t = (thr_pkg::TW'(e_fstc) <<< thr_pkg::FRAC_BITS) - thr_pkg::TW'(e_ay);

    dv_tmp = {rem_r, quo_r[thr_pkg::QW-1]};
    dv_ge  = (dv_tmp >= {1'b0, dvs_r});
    dv_rem = dv_ge ? thr_pkg::XW'(dv_tmp - {1'b0, dvs_r}) : dv_tmp[thr_pkg::XW-1:0];
    dv_quo = {quo_r[thr_pkg::QW-2:0], dv_ge};
    sq     = sgn_r ? -dv_quo : dv_quo;
    ml_acc = pacc_r + (mm_r[0] ? quo_r : '0);
    eo     = ml_acc[thr_pkg::QW-1:thr_pkg::FRAC_BITS];
    eo_s   = sgn_r ? -eo : eo;
    fo_s   = sgn_r ? -ml_acc[thr_pkg::ZACC_W-1:0] : ml_acc[thr_pkg::ZACC_W-1:0];

    xv = xa_r[thr_pkg::ACC_BITS +: thr_pkg::XW];
    zv = za_r[thr_pkg::ACC_BITS +: thr_pkg::ZW];
    cur_lx = valid_r[row_r] ? row_rd_r.lx : thr_pkg::X_TOP;
    cur_hx = valid_r[row_r] ? row_rd_r.hx : thr_pkg::X_BOTTOM;
    row_wd = row_rd_r;
    if (xv < cur_lx) begin
      row_wd.lx = xv; row_wd.lz = zv;
    end else begin
      row_wd.lx = cur_lx;
    end
    if (xv > cur_hx) begin
      row_wd.hx = xv; row_wd.hz = zv;
    end else begin
      row_wd.hx = cur_hx;
    end

    f_fst  = thr_pkg::RC_W'(row_rd_r.lx >>> thr_pkg::FRAC_BITS);
    f_end  = thr_pkg::RC_W'(row_rd_r.hx >>> thr_pkg::FRAC_BITS);
    f_endc = (f_end > thr_pkg::MAP_SIZE) ? thr_pkg::RC_W'(thr_pkg::MAP_SIZE) : f_end;
    f_dx   = (thr_pkg::XW+1)'(row_rd_r.hx) - (thr_pkg::XW+1)'(row_rd_r.lx);
    f_dz   = (thr_pkg::ZW+1)'(row_rd_r.hz) - (thr_pkg::ZW+1)'(row_rd_r.lz);
    f_dzm  = f_dz[thr_pkg::ZW] ? (thr_pkg::ZW+1)'(-f_dz) : f_dz;
    f_skip = !valid_r[row_r] || !(row_rd_r.lx < row_rd_r.hx) || (f_endc <= 0)
             || (f_fst >= thr_pkg::MAP_SIZE) || (f_fst >= f_endc);
    pz_v   = za_r[thr_pkg::ACC_BITS +: thr_pkg::ZW];

    ylo = ay_r;
    if (by_r < ylo) ylo = by_r;
    if (cy_r < ylo) ylo = cy_r;
    yhi = ay_r;
    if (by_r > yhi) yhi = by_r;
    if (cy_r > yhi) yhi = cy_r;
    s_lo = thr_pkg::RC_W'(ylo >>> thr_pkg::FRAC_BITS);
    s_hi = thr_pkg::RC_W'(yhi >>> thr_pkg::FRAC_BITS);
    if (s_lo < 0) s_lo = '0;
    if (s_hi > thr_pkg::MAP_SIZE - 1) s_hi = thr_pkg::RC_W'(thr_pkg::MAP_SIZE - 1);
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; clr_reply_nxt = clr_reply_r;
    ax_nxt = ax_r; ay_nxt = ay_r; az_nxt = az_r;
    bx_nxt = bx_r; by_nxt = by_r; bz_nxt = bz_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    edge_nxt = edge_r; row_nxt = row_r; last_nxt = last_r; col_nxt = col_r; end_nxt = end_r;
    rem_nxt = rem_r; dvs_nxt = dvs_r; t_nxt = t_r; mm_nxt = mm_r; quo_nxt = quo_r;
    pacc_nxt = pacc_r; sgn_nxt = sgn_r;
    xs_nxt = xs_r; xa_nxt = xa_r; zs_nxt = zs_r; za_nxt = za_r;
    cells_nxt = cells_r; min_nxt = min_r; hv_nxt = hv_r;
    rcol_nxt = rcol_r; rrow_nxt = rrow_r; valid_nxt = valid_r;
    store_we = 1'b0; store_wa = cnt_r; store_wd = thr_pkg::EMPTY_HEIGHT;
    row_we = 1'b0;

    unique case (state_r)
      thr_pkg::S_CLEAR: begin
        store_we = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == {thr_pkg::CNT_W{1'b1}}) begin
          state_nxt = clr_reply_r ? thr_pkg::S_OUT : thr_pkg::S_IDLE;
        end
      end
      thr_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          ax_nxt = in_ch.vertex_a_x; ay_nxt = in_ch.vertex_a_y; az_nxt = in_az;
          bx_nxt = in_ch.vertex_b_x; by_nxt = in_ch.vertex_b_y; bz_nxt = in_bz;
          cx_nxt = in_ch.vertex_c_x; cy_nxt = in_ch.vertex_c_y; cz_nxt = in_cz;
          rcol_nxt = in_ch.read_col; rrow_nxt = in_ch.read_row;
          cells_nxt = '0; hv_nxt = '0; edge_nxt = 2'd0;
          unique case (thr_pkg::action_t'(in_ch.action))
            thr_pkg::ACT_DRAW:  state_nxt = thr_pkg::S_EDGE;
            thr_pkg::ACT_READ:  state_nxt = thr_pkg::S_READ_RD;
            thr_pkg::ACT_CLEAR: begin
              state_nxt = thr_pkg::S_CLEAR; cnt_nxt = '0; clr_reply_nxt = 1'b1;
              min_nxt = thr_pkg::TOP_HEIGHT;
            end
            default: state_nxt = thr_pkg::S_OUT;
          endcase
        end
      end
      thr_pkg::S_EDGE: begin
        if (e_skip) begin
          edge_nxt  = edge_r + 2'd1;
          state_nxt = (edge_r == 2'd2) ? thr_pkg::S_SPAN : thr_pkg::S_EDGE;
        end else begin
          row_nxt  = thr_pkg::IDX_W'(e_fstc);
          last_nxt = thr_pkg::IDX_W'(e_lstc);
          t_nxt    = thr_pkg::XW'(e_t);
          dvs_nxt  = thr_pkg::XW'(e_dy);
          rem_nxt  = '0;
          quo_nxt  = thr_pkg::QW'(e_dxm) << (thr_pkg::FRAC_BITS + thr_pkg::ACC_BITS);
          sgn_nxt  = e_dx[thr_pkg::XW];
          cnt_nxt  = '0;
          state_nxt = thr_pkg::S_DIVX;
        end
      end
      thr_pkg::S_DIVX, thr_pkg::S_DIVZ, thr_pkg::S_DIVR: begin
        rem_nxt = dv_rem; quo_nxt = dv_quo; cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == thr_pkg::CNT_W'(thr_pkg::QW - 1)) begin
          cnt_nxt = '0; pacc_nxt = '0;
          priority if (state_r == thr_pkg::S_DIVX) begin
            xs_nxt = sq[thr_pkg::XACC_W-1:0]; mm_nxt = t_r; state_nxt = thr_pkg::S_MULX;
          end else if (state_r == thr_pkg::S_DIVZ) begin
            zs_nxt = sq[thr_pkg::ZACC_W-1:0]; mm_nxt = t_r; state_nxt = thr_pkg::S_MULZ;
          end else begin
            zs_nxt = sq[thr_pkg::ZACC_W-1:0]; state_nxt = thr_pkg::S_MULR;
          end
        end
      end
      thr_pkg::S_MULX, thr_pkg::S_MULZ, thr_pkg::S_MULR: begin
        pacc_nxt = ml_acc; quo_nxt = quo_r << 1; mm_nxt = mm_r >> 1; cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == thr_pkg::CNT_W'(thr_pkg::XW - 1)) begin
          cnt_nxt = '0;
          priority if (state_r == thr_pkg::S_MULX) begin
            xa_nxt = {{(thr_pkg::XACC_W - thr_pkg::XW - thr_pkg::ACC_BITS){e_ax[thr_pkg::XW-1]}},
                      e_ax, {thr_pkg::ACC_BITS{1'b0}}} + eo_s[thr_pkg::XACC_W-1:0];
            rem_nxt = '0;
            quo_nxt = thr_pkg::QW'(e_dzm) << (thr_pkg::FRAC_BITS + thr_pkg::ACC_BITS);
            sgn_nxt = e_dz[thr_pkg::ZW];
            state_nxt = thr_pkg::S_DIVZ;
          end else if (state_r == thr_pkg::S_MULZ) begin
            za_nxt = {{(thr_pkg::ZACC_W - thr_pkg::ZW - thr_pkg::ACC_BITS){e_az[thr_pkg::ZW-1]}},
                      e_az, {thr_pkg::ACC_BITS{1'b0}}} + eo_s;
            state_nxt = thr_pkg::S_WALK_RD;
          end else begin
            za_nxt = {{(thr_pkg::ZACC_W - thr_pkg::ZW - thr_pkg::ACC_BITS){row_rd_r.lz[thr_pkg::ZW-1]}},
                      row_rd_r.lz, {thr_pkg::ACC_BITS{1'b0}}} + fo_s;
            state_nxt = thr_pkg::S_PIX;
          end
        end
      end
      thr_pkg::S_WALK_RD: state_nxt = thr_pkg::S_WALK_WR;
      thr_pkg::S_WALK_WR: begin
        row_we = 1'b1;
        valid_nxt[row_r] = 1'b1;
        xa_nxt = xa_r + xs_r;
        za_nxt = za_r + zs_r;
        if (row_r == last_r) begin
          edge_nxt  = edge_r + 2'd1;
          state_nxt = (edge_r == 2'd2) ? thr_pkg::S_SPAN : thr_pkg::S_EDGE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = thr_pkg::S_WALK_RD;
        end
      end
      thr_pkg::S_SPAN: begin
        if (s_lo > s_hi) begin
          state_nxt = thr_pkg::S_OUT;
        end else begin
          row_nxt = thr_pkg::IDX_W'(s_lo); last_nxt = thr_pkg::IDX_W'(s_hi);
          state_nxt = thr_pkg::S_ROW_RD;
        end
      end
      thr_pkg::S_ROW_RD: state_nxt = thr_pkg::S_ROW_CHK;
      thr_pkg::S_ROW_CHK: begin
        valid_nxt[row_r] = 1'b0;
        if (f_skip) begin
          if (row_r == last_r) begin
            state_nxt = thr_pkg::S_OUT;
          end else begin
            row_nxt = row_r + 1'b1; state_nxt = thr_pkg::S_ROW_RD;
          end
        end else begin
          dvs_nxt = thr_pkg::XW'(f_dx);
          rem_nxt = '0;
          quo_nxt = thr_pkg::QW'(f_dzm) << (thr_pkg::FRAC_BITS + thr_pkg::ACC_BITS);
          sgn_nxt = f_dz[thr_pkg::ZW];
          mm_nxt  = (f_fst < 0) ? thr_pkg::XW'(-f_fst) : '0;
          col_nxt = (f_fst < 0) ? '0 : thr_pkg::IDX_W'(f_fst);
          end_nxt = (thr_pkg::IDX_W+1)'(f_endc);
          cnt_nxt = '0;
          state_nxt = thr_pkg::S_DIVR;
        end
      end
      thr_pkg::S_PIX: begin
        store_we = 1'b1;
        store_wa = {row_r, col_r};
        store_wd = pz_v;
        if (pz_v < min_r) min_nxt = pz_v;
        if (cells_r != thr_pkg::CELLS_MAX) cells_nxt = cells_r + 1'b1;
        za_nxt  = za_r + zs_r;
        col_nxt = col_r + 1'b1;
        if ({1'b0, col_r} + 1'b1 == end_r) begin
          if (row_r == last_r) begin
            state_nxt = thr_pkg::S_OUT;
          end else begin
            row_nxt = row_r + 1'b1; state_nxt = thr_pkg::S_ROW_RD;
          end
        end
      end
      thr_pkg::S_READ_RD: state_nxt = thr_pkg::S_READ_DAT;
      thr_pkg::S_READ_DAT: begin
        hv_nxt = rd_inmap ? store_rd_r : thr_pkg::EMPTY_HEIGHT;
        state_nxt = thr_pkg::S_OUT;
      end
      thr_pkg::S_OUT: begin
        if (out_ch.ready) state_nxt = thr_pkg::S_IDLE;
      end
      default: state_nxt = thr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= thr_pkg::S_CLEAR;
      cnt_r <= '0;
      clr_reply_r <= 1'b0;
      min_r <= thr_pkg::TOP_HEIGHT;
      valid_r <= '0;
      edge_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      min_r <= min_nxt;
      valid_r <= valid_nxt;
      edge_r <= edge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; ay_r <= ay_nxt; az_r <= az_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; bz_r <= bz_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    row_r <= row_nxt; last_r <= last_nxt; col_r <= col_nxt; end_r <= end_nxt;
    rem_r <= rem_nxt; dvs_r <= dvs_nxt; t_r <= t_nxt; mm_r <= mm_nxt;
    quo_r <= quo_nxt; pacc_r <= pacc_nxt; sgn_r <= sgn_nxt;
    xs_r <= xs_nxt; xa_r <= xa_nxt; zs_r <= zs_nxt; za_r <= za_nxt;
    cells_r <= cells_nxt; hv_r <= hv_nxt;
    rcol_r <= rcol_nxt; rrow_r <= rrow_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_rd_r <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_r] <= row_wd;
    row_rd_r <= row_mem[row_r];
  end

endmodule
